// ===== rtl/core/bda_pkg.sv =====
`default_nettype none

package bda_pkg;

    localparam int VALUE_W     = 32;
    localparam int DIGIT_COUNT = 10;
    localparam int BCD_W       = 4 * DIGIT_COUNT;
    localparam int STEP_W      = $clog2(VALUE_W);
    localparam int POS_W       = $clog2(DIGIT_COUNT);
    localparam int CHAR_W      = 6;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 8;

    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(VALUE_W - 1);
    localparam logic [POS_W-1:0]  POS_TOP    = POS_W'(DIGIT_COUNT - 1);
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;
    localparam logic [CHAR_W-1:0] ASCII_NUL  = 6'h00;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_HALF = 2'd1;
    localparam logic [1:0] OP_WORD = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII converter.
// Input channel s_axis: one item carries a mode (op) and a 32-bit value.
// Byte and halfword modes use the low 8 or 16 bits and drop leading zeros,
// giving at least one digit; word mode (and the unused code 3) gives ten
// zero-padded digits.
// Output channel m_axis: one item per character, most significant digit
// first, then a NUL terminator flagged with tlast.
// Sequence: after an item is accepted, the value runs through shift-and-add-3
// in one shared dabble stage, then the leading digit is located, then the
// characters follow, one per cycle while the receiver is ready. The next item
// is accepted only after the terminator has been taken.
// A stalled receiver holds the current character and the whole sequencer.
// Reset returns the block to idle with no output valid.
`default_nettype none

module binary_to_decimal_ascii (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // op [1:0], value [33:2], zero fill [39:34]
    input  wire logic [bda_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // ascii_char [5:0], zero fill [7:6]
    output logic      [bda_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                                m_axis_tlast
);
    import bda_pkg::*;

    state_t               state_reg, state_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 pad_reg, pad_next;
    logic                 term_reg, term_next;

    logic [1:0]           in_op;
    logic [VALUE_W-1:0]   in_value;
    logic [VALUE_W-1:0]   masked_value;
    logic [BCD_W-1:0]     dabble_out;
    logic [POS_W-1:0]     lead_pos;
    logic [3:0]           cur_digit;
    logic [CHAR_W-1:0]    cur_char;

    assign in_op    = s_axis_tdata[1:0];
    assign in_value = s_axis_tdata[VALUE_W+1:2];

    bda_dabble u_dabble (
        .bcd_in  (bcd_reg),
        .bit_in  (value_reg[VALUE_W-1]),
        .bcd_out (dabble_out)
    );

    always_comb
    begin
        case (in_op)
            OP_BYTE: masked_value = {{(VALUE_W-8){1'b0}}, in_value[7:0]};
            OP_HALF: masked_value = {{(VALUE_W-16){1'b0}}, in_value[15:0]};
            default: masked_value = in_value;
        endcase
    end

    // highest nonzero digit, digit 0 when all are zero
    always_comb
    begin
        lead_pos = '0;
        for (int d = 1; d < DIGIT_COUNT; d++)
        begin
            if (bcd_reg[4*d +: 4] != 4'd0)
            begin
                lead_pos = POS_W'(d);
            end
        end
    end

    always_comb
    begin
        cur_digit = 4'd0;
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            if (pos_reg == POS_W'(d))
            begin
                cur_digit = bcd_reg[4*d +: 4];
            end
        end
    end

    assign cur_char = term_reg ? ASCII_NUL : (ASCII_ZERO + {2'b00, cur_digit});

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = {{(OUT_DATA_W-CHAR_W){1'b0}}, cur_char};
    assign m_axis_tlast  = term_reg;

    always_comb
    begin
        state_next = state_reg;
        value_next = value_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        pos_next   = pos_reg;
        pad_next   = pad_reg;
        term_next  = term_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    value_next = masked_value;
                    bcd_next   = '0;
                    step_next  = '0;
                    term_next  = 1'b0;
                    pad_next   = !(in_op inside {OP_BYTE, OP_HALF});
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next   = dabble_out;
                value_next = {value_reg[VALUE_W-2:0], 1'b0};
                step_next  = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                pos_next   = pad_reg ? POS_TOP : lead_pos;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_axis_tready)
                begin
                    if (term_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (pos_reg == '0)
                    begin
                        term_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            pos_reg   <= '0;
            pad_reg   <= 1'b0;
            term_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pos_reg   <= pos_next;
            pad_reg   <= pad_next;
            term_reg  <= term_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        bcd_reg   <= bcd_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/bda_dabble.sv =====
`default_nettype none

module bda_dabble (
    input  wire logic [bda_pkg::BCD_W-1:0] bcd_in,
    input  wire logic                      bit_in,
    output logic      [bda_pkg::BCD_W-1:0] bcd_out
);
    import bda_pkg::*;

    logic [BCD_W-1:0] adjusted;

    // add 3 to every digit of 5 or more, then shift in the next binary bit
    always_comb
    begin
        logic [3:0] digit;
        adjusted = '0;
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            digit = bcd_in[4*d +: 4];
            if (digit >= 4'd5)
            begin
                adjusted[4*d +: 4] = digit + 4'd3;
            end
            else
            begin
                adjusted[4*d +: 4] = digit;
            end
        end
    end

    assign bcd_out = {adjusted[BCD_W-2:0], bit_in};

endmodule

`default_nettype wire

// ===== test/tb_binary_to_decimal_ascii.sv =====
`timescale 1ns / 100ps

module tb_binary_to_decimal_ascii;

    import bda_pkg::*;

    localparam logic [1:0] OP_UNDEF    = 2'd3;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         TAIL_CYCLES = 60;
    localparam int         RAND_ITEMS  = 147;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              term;
    } char_result_t;

    class char_scoreboard;
        char_result_t expected_chars[$];
        int           fail_count;

        function new();
            fail_count = 0;
        endfunction

        // decimal digits of the masked value, leading zeros dropped in the short modes
        function void note_item(input logic [1:0] op, input logic [31:0] value);
            logic [31:0] rest;
            logic [3:0]  digits [DIGIT_COUNT];
            int          width;
            case (op)
                OP_BYTE: rest = {24'b0, value[7:0]};
                OP_HALF: rest = {16'b0, value[15:0]};
                default: rest = value;
            endcase
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                digits[i] = 4'(rest % 10);
                rest = rest / 10;
            end
            width = DIGIT_COUNT;
            if (op == OP_BYTE || op == OP_HALF)
            begin
                width = 1;
                for (int i = DIGIT_COUNT - 1; i > 0; i--)
                    if (digits[i] != 0 && width == 1)
                        width = i + 1;
            end
            for (int i = width - 1; i >= 0; i--)
                expected_chars.push_back('{ASCII_ZERO + CHAR_W'(digits[i]), 1'b0});
            expected_chars.push_back('{ASCII_NUL, 1'b1});
        endfunction

        function void check_char(input logic [OUT_DATA_W-1:0] data, input logic term);
            char_result_t exp_char;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected char, got data %h last %b", $time, data, term);
                fail_count++;
                return;
            end
            exp_char = expected_chars.pop_front();
            if (data !== {{(OUT_DATA_W - CHAR_W){1'b0}}, exp_char.code})
            begin
                $display("%0t: char mismatch, expected %h got %h", $time, exp_char.code, data);
                fail_count++;
            end
            if (term !== exp_char.term)
            begin
                $display("%0t: last mismatch, expected %b got %b", $time, exp_char.term, term);
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void report_leftover();
            if (expected_chars.size() != 0)
            begin
                $display("%0t: %0d chars expected but never seen, next expected %h",
                         $time, expected_chars.size(), expected_chars[0].code);
                fail_count++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    char_scoreboard sb = new();
    logic           idle_en;
    int             stall_left;
    int             quiet_cycles;

    binary_to_decimal_ascii dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        int          r;
        logic [31:0] p;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom >> $urandom_range(0, 31);
        else if (r < 8)
            return $urandom;
        p = 1;
        repeat ($urandom_range(0, 9))
            p = p * 10;
        // right at or just below a power of ten
        return p - $urandom_range(0, 1);
    endfunction

    // receiver side stalls
    always @(posedge clk)
    begin
        if (!idle_en)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 65)
            m_axis_tready <= 1'b1;
        else
        begin
            stall_left = pick_gap();
            m_axis_tready <= 1'b0;
        end
    end

    // output check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_char(m_axis_tdata, m_axis_tlast);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d chars pending", $time, sb.pending());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // call at a rising edge; returns at the rising edge where the gap ends
    task automatic send_item(input logic [1:0] op, input logic [31:0] value, input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - VALUE_W - 2){1'b0}}, value, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_item(op, value);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        idle_en       = 1'b1;
        stall_left    = 0;
        quiet_cycles  = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte mode: zero, digit count boundaries, upper bits ignored
        send_item(OP_BYTE, 32'd0, pick_gap());
        send_item(OP_BYTE, 32'd9, pick_gap());
        send_item(OP_BYTE, 32'd10, pick_gap());
        send_item(OP_BYTE, 32'd99, pick_gap());
        send_item(OP_BYTE, 32'd100, pick_gap());
        send_item(OP_BYTE, 32'd255, pick_gap());
        send_item(OP_BYTE, 32'hFFFF_FF00, pick_gap());
        send_item(OP_BYTE, 32'h1234_5678, pick_gap());
        // halfword mode
        send_item(OP_HALF, 32'd0, pick_gap());
        send_item(OP_HALF, 32'd9999, pick_gap());
        send_item(OP_HALF, 32'd10000, pick_gap());
        send_item(OP_HALF, 32'd65535, pick_gap());
        send_item(OP_HALF, 32'hFFFF_0000, pick_gap());
        send_item(OP_HALF, 32'hABCD_0100, pick_gap());
        // word mode, always ten digits
        send_item(OP_WORD, 32'd0, pick_gap());
        send_item(OP_WORD, 32'd1, pick_gap());
        send_item(OP_WORD, 32'd999999999, pick_gap());
        send_item(OP_WORD, 32'd1000000000, pick_gap());
        send_item(OP_WORD, 32'hFFFF_FFFF, pick_gap());
        send_item(OP_WORD, 32'h8000_0000, pick_gap());
        // unused mode code behaves as word mode
        send_item(OP_UNDEF, 32'd0, pick_gap());
        send_item(OP_UNDEF, 32'hFFFF_FFFF, pick_gap());
        send_item(OP_UNDEF, 32'd123, pick_gap());
        drain();

        // back to back with the receiver always ready first
        idle_en = 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 40)
                idle_en = 1'b1;
            if (n == 100)
                drain();
            send_item(2'($urandom_range(0, 3)), pick_value(), idle_en ? pick_gap() : 0);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        sb.report_leftover();
        if (sb.fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
